>>> hdl/mtep_pkg.sv
// Package for the track event parser: request and result payload types
// and the result kind codes. No dependencies.
package mtep_pkg;

	// Result kind codes
	localparam logic [3:0] KIND_NOTE_OFF  = 4'd0;
	localparam logic [3:0] KIND_PITCH     = 4'd6;
	localparam logic [3:0] KIND_SYSEX     = 4'd7;
	localparam logic [3:0] KIND_SYSEX_BYTE = 4'd8;
	localparam logic [3:0] KIND_EOT       = 4'd9;
	localparam logic [3:0] KIND_TEMPO     = 4'd10;
	localparam logic [3:0] KIND_UNKNOWN   = 4'd11;
	localparam logic [3:0] KIND_EMPTY     = 4'd12;
	localparam logic [3:0] KIND_ERROR     = 4'd13;

	// Byte values with a fixed meaning in the stream
	localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
	localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
	localparam logic [7:0] BYTE_SONG_POS    = 8'hF2;
	localparam logic [7:0] BYTE_SONG_SEL    = 8'hF3;
	localparam logic [7:0] BYTE_META        = 8'hFF;
	localparam logic [7:0] META_EOT         = 8'h2F;
	localparam logic [7:0] META_TEMPO       = 8'h51;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       track_start;
		logic       data_end;
	} item_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [3:0]  channel;
		logic [27:0] delta_time;
		logic [23:0] first_param;
		logic [7:0]  second_param;
		logic [7:0]  meta_kind;
		logic [7:0]  sysex_count;
		logic        track_last;
	} result_t;

endpackage

>>> hdl/midi_track_event_parser_unit.sv
// Track event parser top level: byte-wide parse state machine and a
// two-entry result buffer. Depends on mtep_pkg.
//
// channel  direction  handshake                    payload
// item     in         item_valid / item_stall      mtep_pkg::item_t
// result   out        result_valid / result_stall  mtep_pkg::result_t
//
// One byte is taken every cycle while item_stall is low; the parse state
// and the result buffer are updated at the edge that accepts the byte, which
// writes the result into the main register, or into the skid register while
// the main one is held. item_stall rises only while the skid register is full.
// arst_n clears the parse state to idle and empties both result registers.
module midi_track_event_parser_unit #(
	parameter int unsigned SYSEX_MAX = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  mtep_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output mtep_pkg::result_t result
);
	import mtep_pkg::*;

	localparam logic [7:0] SYSEX_LIM = 8'(SYSEX_MAX);

	typedef enum logic [12:0] {
		PH_IDLE       = 13'b0000000000001,
		PH_LEN        = 13'b0000000000010,
		PH_DELTA      = 13'b0000000000100,
		PH_STATUS     = 13'b0000000001000,
		PH_PARAM1     = 13'b0000000010000,
		PH_PARAM2     = 13'b0000000100000,
		PH_SYSEX      = 13'b0000001000000,
		PH_META_TYPE  = 13'b0000010000000,
		PH_META_LEN   = 13'b0000100000000,
		PH_TEMPO      = 13'b0001000000000,
		PH_SKIP_TEMPO = 13'b0010000000000,
		PH_SKIP_UNK   = 13'b0100000000000,
		PH_DRAIN      = 13'b1000000000000
	} phase_t;

	typedef enum logic [2:0] {
		EV_CONT,
		EV_DONE,
		EV_ECHO,
		EV_FAIL,
		EV_EOT
	} ev_t;

	phase_t      phase_q, phase_d;
	logic [31:0] bytes_left_q, bytes_left_d;
	logic [1:0]  len_seen_q, len_seen_d;
	logic [7:0]  run_status_q, run_status_d;
	logic [27:0] vl_value_q, vl_value_d;
	logic [2:0]  vl_bytes_q, vl_bytes_d;
	logic [27:0] delta_q, delta_d;
	logic [23:0] param_q, param_d;
	logic [7:0]  meta_q, meta_d;
	logic [27:0] skip_q, skip_d;
	logic [7:0]  sysex_q, sysex_d;

	result_t     res_d;
	logic        push;
	ev_t         ev;

	logic        accept;
	logic [7:0]  b;
	logic [31:0] bl_dec;
	logic [27:0] vl_take;
	logic [2:0]  vb_take;
	logic [3:0]  hi;
	logic [3:0]  ch_kind;
	logic [2:0]  tempo_cnt;
	logic [23:0] tempo_val;
	logic [27:0] skip_dec;
	logic [7:0]  sysex_inc;

	result_t     out_q, skid_q;
	logic        out_vld_q, skid_vld_q;
	logic        pop;

	assign accept    = item_valid && !item_stall;
	assign b         = item.data_byte;
	assign bl_dec    = bytes_left_q - 32'd1;
	assign vl_take   = {vl_value_q[20:0], b[6:0]};
	assign vb_take   = vl_bytes_q + 3'd1;
	assign hi        = run_status_q[7:4];
	assign ch_kind   = {1'b0, hi[2:0]};
	assign tempo_cnt = vl_bytes_q + 3'd1;
	assign tempo_val = {param_q[15:0], b};
	assign skip_dec  = skip_q - 28'd1;
	assign sysex_inc = sysex_q + 8'd1;

	// Parse one byte: next state and an optional result
	always_comb begin
		phase_d      = phase_q;
		bytes_left_d = bytes_left_q;
		len_seen_d   = len_seen_q;
		run_status_d = run_status_q;
		vl_value_d   = vl_value_q;
		vl_bytes_d   = vl_bytes_q;
		delta_d      = delta_q;
		param_d      = param_q;
		meta_d       = meta_q;
		skip_d       = skip_q;
		sysex_d      = sysex_q;
		res_d        = '0;
		res_d.delta_time = delta_q;
		push         = 1'b0;
		ev           = EV_CONT;

		if (accept) begin
			if (item.data_end) begin
				// Source ran dry: error only inside a track
				if (phase_q != PH_IDLE && phase_q != PH_DRAIN) begin
					res_d            = '0;
					res_d.kind       = KIND_ERROR;
					res_d.track_last = 1'b1;
					push             = 1'b1;
					delta_d          = '0;
				end
				phase_d = PH_IDLE;
			end else if (item.track_start) begin
				// Restart: clear all state, take the top length byte
				bytes_left_d = {b, 24'd0};
				len_seen_d   = 2'd1;
				run_status_d = '0;
				vl_value_d   = '0;
				vl_bytes_d   = '0;
				delta_d      = '0;
				param_d      = '0;
				meta_d       = '0;
				skip_d       = '0;
				sysex_d      = '0;
				phase_d      = PH_LEN;
			end else begin
				case (phase_q)
					PH_IDLE: begin
					end
					PH_LEN: begin
						bytes_left_d = {bytes_left_q[23:0], b};
						len_seen_d   = len_seen_q + 2'd1;
						if (len_seen_d == 2'd0) begin
							if (bytes_left_d == 32'd0) begin
								phase_d          = PH_IDLE;
								delta_d          = '0;
								res_d            = '0;
								res_d.kind       = KIND_EMPTY;
								res_d.track_last = 1'b1;
								push             = 1'b1;
							end else begin
								vl_value_d = '0;
								vl_bytes_d = '0;
								phase_d    = PH_DELTA;
							end
						end
					end
					PH_DRAIN: begin
						bytes_left_d = bl_dec;
						if (bl_dec == 32'd0) begin
							phase_d = PH_IDLE;
						end
					end
					default: begin
						bytes_left_d = bl_dec;
						// Event byte
						case (phase_q)
							PH_DELTA: begin
								vl_value_d = vl_take;
								vl_bytes_d = vb_take;
								if (b[7]) begin
									if (vb_take >= 3'd4) begin
										ev = EV_FAIL;
									end
								end else begin
									delta_d = vl_take;
									phase_d = PH_STATUS;
								end
							end
							PH_STATUS, PH_PARAM1: begin
								if (phase_q == PH_STATUS && b[7]) begin
									if (b[7:4] != 4'hF) begin
										run_status_d = b;
										phase_d      = PH_PARAM1;
									end else begin
										// System status cancels running status
										run_status_d = '0;
										meta_d       = '0;
										if (b == BYTE_SYSEX_START) begin
											sysex_d = '0;
											phase_d = PH_SYSEX;
										end else if (b == BYTE_META) begin
											phase_d = PH_META_TYPE;
										end else if (b == BYTE_SONG_POS) begin
											skip_d  = 28'd2;
											phase_d = PH_SKIP_UNK;
										end else if (b == BYTE_SONG_SEL) begin
											skip_d  = 28'd1;
											phase_d = PH_SKIP_UNK;
										end else begin
											res_d.kind = KIND_UNKNOWN;
											ev         = EV_DONE;
										end
									end
								end else if (phase_q == PH_STATUS && run_status_q == 8'd0) begin
									ev = EV_FAIL;
								end else if (hi == 4'hC || hi == 4'hD) begin
									// One-parameter channel message
									res_d.kind        = ch_kind;
									res_d.channel     = run_status_q[3:0];
									res_d.first_param = {16'd0, b};
									ev                = EV_DONE;
								end else begin
									param_d = {16'd0, b};
									phase_d = PH_PARAM2;
								end
							end
							PH_PARAM2: begin
								res_d.channel = run_status_q[3:0];
								if (hi == 4'hE) begin
									res_d.kind        = KIND_PITCH;
									res_d.first_param = {10'd0, b[6:0], param_q[6:0]};
								end else begin
									res_d.kind         = ch_kind;
									res_d.first_param  = param_q;
									res_d.second_param = b;
								end
								ev = EV_DONE;
							end
							PH_SYSEX: begin
								if (b == BYTE_SYSEX_END) begin
									res_d.kind        = KIND_SYSEX;
									res_d.sysex_count = sysex_q;
									ev                = EV_DONE;
								end else if (sysex_q >= SYSEX_LIM) begin
									ev = EV_FAIL;
								end else begin
									// Echo the payload byte
									sysex_d            = sysex_inc;
									res_d.kind         = KIND_SYSEX_BYTE;
									res_d.second_param = b;
									res_d.sysex_count  = sysex_inc;
									ev                 = EV_ECHO;
								end
							end
							PH_META_TYPE: begin
								meta_d     = b;
								vl_value_d = '0;
								vl_bytes_d = '0;
								phase_d    = PH_META_LEN;
							end
							PH_META_LEN: begin
								vl_value_d = vl_take;
								vl_bytes_d = vb_take;
								if (b[7]) begin
									if (vb_take >= 3'd4) begin
										ev = EV_FAIL;
									end
								end else if (meta_q == META_EOT) begin
									res_d.kind      = KIND_EOT;
									res_d.meta_kind = meta_q;
									ev              = EV_EOT;
								end else if (meta_q == META_TEMPO) begin
									param_d    = '0;
									vl_bytes_d = '0;
									skip_d     = (vl_take > 28'd3) ? vl_take - 28'd3 : '0;
									phase_d    = PH_TEMPO;
								end else begin
									skip_d = vl_take;
									if (vl_take == 28'd0) begin
										res_d.kind      = KIND_UNKNOWN;
										res_d.meta_kind = meta_q;
										ev              = EV_DONE;
									end else begin
										phase_d = PH_SKIP_UNK;
									end
								end
							end
							PH_TEMPO: begin
								// Collect three tempo bytes, then skip the rest
								param_d    = tempo_val;
								vl_bytes_d = tempo_cnt;
								if (tempo_cnt >= 3'd3) begin
									if (skip_q == 28'd0) begin
										res_d.kind        = KIND_TEMPO;
										res_d.first_param = tempo_val;
										res_d.meta_kind   = meta_q;
										ev                = EV_DONE;
									end else begin
										phase_d = PH_SKIP_TEMPO;
									end
								end
							end
							PH_SKIP_TEMPO, PH_SKIP_UNK: begin
								skip_d = skip_dec;
								if (skip_dec == 28'd0) begin
									res_d.meta_kind = meta_q;
									if (phase_q == PH_SKIP_TEMPO) begin
										res_d.kind        = KIND_TEMPO;
										res_d.first_param = param_q;
									end else begin
										res_d.kind = KIND_UNKNOWN;
									end
									ev = EV_DONE;
								end
							end
							default: begin
								ev = EV_FAIL;
							end
						endcase

						// Settle the event against the track length
						if (ev == EV_FAIL ||
						    ((ev == EV_CONT || ev == EV_ECHO) && bl_dec == 32'd0)) begin
							phase_d          = PH_IDLE;
							delta_d          = '0;
							res_d            = '0;
							res_d.kind       = KIND_ERROR;
							res_d.track_last = 1'b1;
							push             = 1'b1;
						end else if (ev == EV_ECHO) begin
							push = 1'b1;
						end else if (ev == EV_EOT) begin
							phase_d          = (bl_dec != 32'd0) ? PH_DRAIN : PH_IDLE;
							res_d.track_last = 1'b1;
							push             = 1'b1;
						end else if (ev == EV_DONE) begin
							push = 1'b1;
							if (bl_dec == 32'd0) begin
								phase_d          = PH_IDLE;
								res_d.track_last = 1'b1;
							end else begin
								vl_value_d = '0;
								vl_bytes_d = '0;
								phase_d    = PH_DELTA;
							end
						end
					end
				endcase
			end
		end
	end

	// Parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bytes_left_q <= '0;
			len_seen_q   <= '0;
			run_status_q <= '0;
			vl_value_q   <= '0;
			vl_bytes_q   <= '0;
			delta_q      <= '0;
			param_q      <= '0;
			meta_q       <= '0;
			skip_q       <= '0;
			sysex_q      <= '0;
		end else begin
			phase_q      <= phase_d;
			bytes_left_q <= bytes_left_d;
			len_seen_q   <= len_seen_d;
			run_status_q <= run_status_d;
			vl_value_q   <= vl_value_d;
			vl_bytes_q   <= vl_bytes_d;
			delta_q      <= delta_d;
			param_q      <= param_d;
			meta_q       <= meta_d;
			skip_q       <= skip_d;
			sysex_q      <= sysex_d;
		end
	end

	// Result buffer: hold a stalled result, park the next one in the skid
	assign pop = out_vld_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) begin
				skid_vld_q <= 1'b0;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_vld_q && !pop) begin
				skid_q <= res_d;
			end else begin
				out_q <= res_d;
			end
		end
	end

	assign item_stall   = skid_vld_q;
	assign result_valid = out_vld_q;
	assign result       = out_q;

`ifndef SYNTH
	// Skid entry is only used behind a full main register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register full while main result register empty");

	// An error result always closes the track
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.kind == KIND_ERROR) |-> out_q.track_last)
		else $error("error result without track_last");

	// A track start request moves the parser to length collection
	a_start_len: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.track_start && !item.data_end) |=> (phase_q == PH_LEN))
		else $error("track start did not enter length phase");

	// A request taken while a result is parked would be lost
	a_no_push_on_skid: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> !push)
		else $error("result produced while skid register full");
`endif

endmodule
